[design/fdfmt_pkg.sv]
// Shared types and constants for the fixed decimal to ASCII formatter.
// Used by the digit cells, the sequencer, the top level and the checker.
package fdfmt_pkg;

	localparam int DEF_MANTISSA_BITS = 96;
	localparam int DEF_MAX_DIGITS    = 29;

	localparam int IN_LOW_W  = 64;
	localparam int IN_HIGH_W = 32;
	localparam int IN_BITS   = IN_LOW_W + IN_HIGH_W;
	localparam int SCALE_W   = 5;
	localparam int DIGIT_W   = 4;
	localparam int CHAR_W    = 8;

	localparam logic [DIGIT_W-1:0] DIGIT_HALF = 4'd5;
	localparam logic [DIGIT_W:0]   DIGIT_BASE = 5'd10;

	localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_POINT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'h0A;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_CLEAR,
		CELL_DABBLE,
		CELL_SHIFT
	} cell_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_DIGIT,
		ST_NEWLINE
	} seq_state_t;

endpackage

[design/fdfmt_digit_cell.sv]
// One decimal digit cell of the conversion chain.
// Clears its digit, doubles its digit plus the carry from below, or shifts in its lower neighbor.
// Depends on fdfmt_pkg.
module fdfmt_digit_cell (
	input  logic                     clk,
	input  fdfmt_pkg::cell_op_t      op,
	input  logic                     carry_in,
	input  logic [fdfmt_pkg::DIGIT_W-1:0] digit_in,
	output logic                     carry_out,
	output logic [fdfmt_pkg::DIGIT_W-1:0] digit_out
);
	import fdfmt_pkg::*;

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W:0]   twice;
	logic [DIGIT_W:0]   adjusted;

	// 2d + c reaches ten exactly when d is five or more
	assign carry_out = (digit_q >= DIGIT_HALF);
	assign twice     = {digit_q, carry_in};
	assign adjusted  = carry_out ? (twice - DIGIT_BASE) : twice;
	assign digit_out = digit_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_CLEAR:  digit_q <= '0;
			CELL_DABBLE: digit_q <= adjusted[DIGIT_W-1:0];
			CELL_SHIFT:  digit_q <= digit_in;
			default:     digit_q <= digit_q;
		endcase
	end

endmodule

[design/fdfmt_seq.sv]
// Sequencer: takes a number, drives the conversion and emits the characters.
// Holds the mantissa shifter, counters and the output register. Depends on fdfmt_pkg.
module fdfmt_seq #(
	parameter int MANTISSA_BITS = fdfmt_pkg::DEF_MANTISSA_BITS,
	parameter int MAX_DIGITS    = fdfmt_pkg::DEF_MAX_DIGITS
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [fdfmt_pkg::IN_BITS-1:0]   mantissa,
	input  logic                            negative,
	input  logic [fdfmt_pkg::SCALE_W-1:0]   scale,
	output fdfmt_pkg::cell_op_t             cell_op,
	output logic                            serial_bit,
	input  logic [fdfmt_pkg::DIGIT_W-1:0]   top_digit,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [fdfmt_pkg::CHAR_W-1:0]    character,
	output logic                            last
);
	import fdfmt_pkg::*;

	localparam int BIT_W = $clog2(MANTISSA_BITS);
	localparam int POS_W = $clog2(MAX_DIGITS + 1);
	localparam int CMP_W = ((POS_W > SCALE_W) ? POS_W : SCALE_W) + 1;

	seq_state_t state_q, state_d;

	logic [MANTISSA_BITS-1:0] mant_q;
	logic [BIT_W-1:0]         bitcnt_q;
	logic [POS_W-1:0]         pos_q;
	logic [SCALE_W-1:0]       scale_q;
	logic                     neg_q;
	logic                     started_q;
	logic                     point_done_q;
	logic                     out_valid_q;
	logic [CHAR_W-1:0]        char_q;
	logic                     last_q;

	logic              accept;
	logic              can_load;
	logic              load;
	logic [CHAR_W-1:0] char_d;
	logic              last_d;
	logic              conv_step;
	logic              pos_step;
	logic              point_set;
	logic              start_set;
	logic              emit;
	logic              point_due;
	logic [CMP_W-1:0]  scale_in_c;
	logic [CMP_W-1:0]  scale_sat_c;
	logic [CMP_W-1:0]  pos_c;
	logic [CMP_W-1:0]  scale_c;

	assign scale_in_c  = CMP_W'(scale);
	assign scale_sat_c = (scale_in_c > CMP_W'(MAX_DIGITS - 1)) ? CMP_W'(MAX_DIGITS - 1)
	                                                           : scale_in_c;
	assign pos_c       = CMP_W'(pos_q);
	assign scale_c     = CMP_W'(scale_q);

	// emit from the first nonzero digit or from the units-before-point position down
	assign emit      = started_q || (top_digit != '0) || (pos_c <= scale_c + CMP_W'(1));
	assign point_due = !point_done_q && (scale_q != '0) && (pos_c == scale_c);
	assign can_load  = !out_valid_q || out_ready;
	assign accept    = (state_q == ST_IDLE) && in_valid;
	assign serial_bit = mant_q[MANTISSA_BITS-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cell_op   = CELL_HOLD;
		load      = 1'b0;
		char_d    = CH_NEWLINE;
		last_d    = 1'b0;
		in_ready  = 1'b0;
		conv_step = 1'b0;
		pos_step  = 1'b0;
		point_set = 1'b0;
		start_set = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cell_op = CELL_CLEAR;
					state_d = ST_CONV;
				end
			end
			ST_CONV: begin
				cell_op   = CELL_DABBLE;
				conv_step = 1'b1;
				if (bitcnt_q == '0) begin
					state_d = ST_SIGN;
				end
			end
			ST_SIGN: begin
				if (!neg_q) begin
					state_d = ST_DIGIT;
				end else if (can_load) begin
					load    = 1'b1;
					char_d  = CH_MINUS;
					state_d = ST_DIGIT;
				end
			end
			ST_DIGIT: begin
				if (!emit) begin
					cell_op  = CELL_SHIFT;
					pos_step = 1'b1;
				end else if (point_due) begin
					if (can_load) begin
						load      = 1'b1;
						char_d    = CH_POINT;
						point_set = 1'b1;
					end
				end else if (can_load) begin
					load      = 1'b1;
					char_d    = CH_ZERO + CHAR_W'(top_digit);
					cell_op   = CELL_SHIFT;
					pos_step  = 1'b1;
					start_set = 1'b1;
					if (pos_q == POS_W'(1)) begin
						state_d = ST_NEWLINE;
					end
				end
			end
			ST_NEWLINE: begin
				if (can_load) begin
					load    = 1'b1;
					char_d  = CH_NEWLINE;
					last_d  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// per-number working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			mant_q   <= mantissa[MANTISSA_BITS-1:0];
			bitcnt_q <= BIT_W'(MANTISSA_BITS - 1);
			pos_q    <= POS_W'(MAX_DIGITS);
			scale_q  <= scale_sat_c[SCALE_W-1:0];
			neg_q    <= negative;
		end else begin
			if (conv_step) begin
				mant_q   <= {mant_q[MANTISSA_BITS-2:0], 1'b0};
				bitcnt_q <= bitcnt_q - BIT_W'(1);
			end
			if (pos_step) begin
				pos_q <= pos_q - POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q    <= 1'b0;
			point_done_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (accept) begin
				started_q    <= 1'b0;
				point_done_q <= 1'b0;
			end else begin
				if (start_set) begin
					started_q <= 1'b1;
				end
				if (point_set) begin
					point_done_q <= 1'b1;
				end
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= char_d;
			last_q <= last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

endmodule

[design/fixed_decimal_to_ascii_formatter_top.sv]
// Fixed decimal to ASCII formatter: after accept it runs one double dabble step per mantissa
// bit, then one digit cell shift per printed or skipped position, with an extra step when a
// point prints; a minus sign is emitted between conversion and the digits. A new number is
// taken only once the closing newline of the previous one is in the output register.
// Reset (arst_n low, asynchronous) returns to idle with no transaction pending.
module fixed_decimal_to_ascii_formatter_top #(
	parameter int MANTISSA_BITS = fdfmt_pkg::DEF_MANTISSA_BITS,
	parameter int MAX_DIGITS    = fdfmt_pkg::DEF_MAX_DIGITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [fdfmt_pkg::IN_LOW_W-1:0]   mantissa_low,
	input  logic [fdfmt_pkg::IN_HIGH_W-1:0]  mantissa_high,
	input  logic                             negative,
	input  logic [fdfmt_pkg::SCALE_W-1:0]    scale,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [fdfmt_pkg::CHAR_W-1:0]     character,
	output logic                             last
);
	import fdfmt_pkg::*;

	// Digit chain: cell 0 is the least significant digit. During conversion each cell doubles
	// its digit and takes the carry of the cell below (cell 0 takes the next
	// mantissa bit); a cell's carry out depends only on its own digit, so there
	// is no ripple. During printing the chain shifts toward the top cell and the
	// sequencer reads the most significant position from the top cell.
	cell_op_t           cell_op;
	logic               serial_bit;
	logic [DIGIT_W-1:0] digits [MAX_DIGITS];
	logic               carries [MAX_DIGITS];

	genvar gi;
	generate
		for (gi = 0; gi < MAX_DIGITS; gi++) begin : g_cell
			if (gi == 0) begin : g_first
				fdfmt_digit_cell u_cell (
					.clk       (clk),
					.op        (cell_op),
					.carry_in  (serial_bit),
					.digit_in  ('0),
					.carry_out (carries[gi]),
					.digit_out (digits[gi])
				);
			end else begin : g_rest
				fdfmt_digit_cell u_cell (
					.clk       (clk),
					.op        (cell_op),
					.carry_in  (carries[gi-1]),
					.digit_in  (digits[gi-1]),
					.carry_out (carries[gi]),
					.digit_out (digits[gi])
				);
			end
		end
	endgenerate

	// Sequencer: accept the transaction, run one dabble step per bit, then emit
	// sign, digits with the point, and the closing newline through the output register.
	fdfmt_seq #(
		.MANTISSA_BITS (MANTISSA_BITS),
		.MAX_DIGITS    (MAX_DIGITS)
	) u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mantissa   ({mantissa_high, mantissa_low}),
		.negative   (negative),
		.scale      (scale),
		.cell_op    (cell_op),
		.serial_bit (serial_bit),
		.top_digit  (digits[MAX_DIGITS-1]),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.character  (character),
		.last       (last)
	);

endmodule

[design/fdfmt_checker.sv]
// Port-level checks for the formatter, attached to the top level by bind.
// Depends on fdfmt_pkg.
module fdfmt_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [fdfmt_pkg::CHAR_W-1:0]  character,
	input logic                          last
);
	import fdfmt_pkg::*;

	// hold a stalled result transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(character) && $stable(last))
		else $error("stalled output changed");

	a_last_newline: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> character == CH_NEWLINE)
		else $error("last without newline");

	a_newline_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && character == CH_NEWLINE |-> last)
		else $error("newline without last");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("accepted twice in a row");

	a_busy_mid_number: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> !in_ready)
		else $error("idle while a number is incomplete");

endmodule

bind fixed_decimal_to_ascii_formatter_top fdfmt_checker u_fdfmt_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.character (character),
	.last      (last)
);
